/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions on clk with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/sirr_pkg.sv */
// ----------------------------------------------------------------------------
// sirr_pkg
// Types and fixed constants of the sky image rotate and remap block.
// ----------------------------------------------------------------------------
package sirr_pkg;

  localparam int STORE_DEPTH = 131072;
  localparam int STORE_AW    = 17;
  localparam int PIX_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Source positions are Q.26 (Q1.14 rotation times Q4.12 scale).
  localparam int FRAC_BITS  = 26;
  localparam int HALF_BITS  = 13;
  localparam int POS_W      = 48;
  localparam int CPROD_W    = 33;
  localparam int IPROD_W    = 44;

  localparam int ZENITH_COL = 166;
  localparam int ZENITH_ROW = 124;
  localparam logic [15:0] ELLIPSE_Q16 = 16'd60031;

  localparam logic signed [POS_W-1:0] ZEN_X = POS_W'(ZENITH_COL) << FRAC_BITS;
  localparam logic signed [POS_W-1:0] ZEN_Y = POS_W'(ZENITH_ROW) << FRAC_BITS;

  localparam logic signed [15:0] COS_RST     = 16'sd16384;
  localparam logic [15:0]        SCALE_X_RST = 16'd4096;
  localparam logic [15:0]        SCALE_Y_RST =
    16'((int'(SCALE_X_RST) * int'(ELLIPSE_Q16) + 32768) >> 16);
  localparam logic signed [CPROD_W-1:0] CX_RST =
    CPROD_W'(int'(COS_RST) * int'(SCALE_X_RST));
  localparam logic signed [CPROD_W-1:0] CY_RST =
    CPROD_W'(int'(COS_RST) * int'(SCALE_Y_RST));

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REGION_SAMPLED   = 2'd0,
    REGION_BEYOND    = 2'd1,
    REGION_HOLE      = 2'd2,
    REGION_OUT_FRAME = 2'd3
  } region_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_OUTER_LIMIT = 3'd2,
    CFG_HOLE_LIMIT  = 3'd3,
    CFG_COS_ROT     = 3'd4,
    CFG_SIN_ROT     = 3'd5,
    CFG_SCALE_X     = 3'd6,
    CFG_HOLE_VALUE  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    op_t         op;
    logic [16:0] load_index;
    logic [31:0] pixel_word;
    logic [9:0]  out_col;
    logic [9:0]  out_row;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] result_word;
    region_t     region;
  } out_beat_t;

endpackage

/* hw/rtl/sirr_ram.sv */
// ----------------------------------------------------------------------------
// sirr_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sirr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/sky_image_rotate_remap.sv */
// A request beat passes stages a, b and c and gives its result from register o;
// a load writes the frame store from stage c and gives no result. Throughput:
// one beat per cycle while the output is not stalled, set by the one read and
// one write port of the frame store in the issue stage. A config write reaches
// the derived scale products in registers, cy_r and sy_r after scale_y_r.
// Reset empties the pipeline and resets the registers; the frame store is kept.
// ----------------------------------------------------------------------------
// sky_image_rotate_remap
// Nearest-neighbor rotate and scale remap of an all-sky frame held in a RAM.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sky_image_rotate_remap #(
  parameter int SRC_WIDTH  = 512,
  parameter int SRC_HEIGHT = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sirr_pkg::in_beat_t          in_beat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sirr_pkg::out_beat_t         out_beat,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sirr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sirr_pkg::CFG_DATA_W-1:0] cfg_data
);

  import sirr_pkg::*;

  localparam int COL_W = $clog2(SRC_WIDTH);
  localparam int ROW_W = $clog2(SRC_HEIGHT);
  localparam logic signed [POS_W-1:0] LIM_X = POS_W'(SRC_WIDTH - 1) << FRAC_BITS;
  localparam logic signed [POS_W-1:0] LIM_Y = POS_W'(SRC_HEIGHT - 1) << FRAC_BITS;

  // Configuration registers.
  logic [9:0]         center_x_r, center_y_r;
  logic [21:0]        outer_lim_r, hole_lim_r;
  logic signed [15:0] cos_r, sin_r;
  logic [15:0]        scale_x_r;
  logic [31:0]        hole_value_r;

  // Derived per-configuration products.
  logic [15:0]               scale_y_r;
  logic [32:0]               scale_y_sum;
  logic signed [CPROD_W-1:0] cx_r, sx_r, cy_r, sy_r;

  // Pipeline stages: a (offset), b (products), c (position and RAM issue), o.
  logic                      a_v_r, b_v_r, c_v_r, o_v_r;
  op_t                       a_op_r, b_op_r, c_op_r;
  logic [STORE_AW-1:0]       a_idx_r, b_idx_r, c_idx_r;
  logic [PIX_W-1:0]          a_pix_r, b_pix_r, c_pix_r;
  logic signed [10:0]        a_dx_r, a_dy_r, in_dx, in_dy;
  logic signed [21:0]        sq_x, sq_y;
  logic [21:0]               b_r2_r;
  logic signed [IPROD_W-1:0] b_pcx_r, b_psy_r, b_psx_r, b_pcy_r;
  region_t                   c_region_r, c_region_nxt, o_region_r;
  logic signed [POS_W-1:0]   c_x_r, c_y_r;
  logic signed [POS_W-1:0]   hx_pos, hy_pos, x_lo, x_hi, y_lo, y_hi;
  logic                      out_of_frame;
  logic [COL_W-1:0]          smp_col;
  logic [ROW_W-1:0]          smp_row;
  logic [STORE_AW-1:0]       rd_addr;
  logic                      free_a, free_b, free_c, free_o;
  logic                      ram_we, ram_re;
  logic [PIX_W-1:0]          ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= '0;
      center_y_r   <= '0;
      outer_lim_r  <= '0;
      hole_lim_r   <= '0;
      cos_r        <= COS_RST;
      sin_r        <= '0;
      scale_x_r    <= SCALE_X_RST;
      hole_value_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CENTER_X:    center_x_r   <= cfg_data[9:0];
        CFG_CENTER_Y:    center_y_r   <= cfg_data[9:0];
        CFG_OUTER_LIMIT: outer_lim_r  <= cfg_data[21:0];
        CFG_HOLE_LIMIT:  hole_lim_r   <= cfg_data[21:0];
        CFG_COS_ROT:     cos_r        <= $signed(cfg_data[15:0]);
        CFG_SIN_ROT:     sin_r        <= $signed(cfg_data[15:0]);
        CFG_SCALE_X:     scale_x_r    <= cfg_data[15:0];
        CFG_HOLE_VALUE:  hole_value_r <= cfg_data;
      endcase
    end
  end

  // Vertical scale is 0.916 of the horizontal one, rounded half up.
  assign scale_y_sum = 33'(32'(scale_x_r) * 32'(ELLIPSE_Q16)) + 33'd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_y_r <= SCALE_Y_RST;
      cx_r      <= CX_RST;
      sx_r      <= '0;
      cy_r      <= CY_RST;
      sy_r      <= '0;
    end else begin
      scale_y_r <= scale_y_sum[31:16];
      cx_r      <= cos_r * $signed({1'b0, scale_x_r});
      sx_r      <= sin_r * $signed({1'b0, scale_x_r});
      cy_r      <= cos_r * $signed({1'b0, scale_y_r});
      sy_r      <= sin_r * $signed({1'b0, scale_y_r});
    end
  end

  // Flow control: a load leaves at the issue stage, so it never waits on the output.
  assign free_o   = !o_v_r || out_ready;
  assign free_c   = !c_v_r || (c_op_r == OP_LOAD) || free_o;
  assign free_b   = !b_v_r || free_c;
  assign free_a   = !a_v_r || free_b;
  assign in_ready = free_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (free_a) begin
        a_v_r <= in_valid;
      end
      if (free_b) begin
        b_v_r <= a_v_r;
      end
      if (free_c) begin
        c_v_r <= b_v_r;
      end
      if (free_o) begin
        o_v_r <= c_v_r && (c_op_r == OP_REQUEST);
      end
    end
  end

  assign in_dx = $signed({1'b0, center_x_r}) - $signed({1'b0, in_beat.out_col});
  assign in_dy = $signed({1'b0, center_y_r}) - $signed({1'b0, in_beat.out_row});
  assign sq_x  = a_dx_r * a_dx_r;
  assign sq_y  = a_dy_r * a_dy_r;

  always_comb begin
    if (b_r2_r >= outer_lim_r) begin
      c_region_nxt = REGION_BEYOND;
    end else if (b_r2_r <= hole_lim_r) begin
      c_region_nxt = REGION_HOLE;
    end else begin
      c_region_nxt = REGION_SAMPLED;
    end
  end

  always_ff @(posedge clk) begin
    if (free_a) begin
      a_op_r  <= in_beat.op;
      a_idx_r <= in_beat.load_index;
      a_pix_r <= in_beat.pixel_word;
      a_dx_r  <= in_dx;
      a_dy_r  <= in_dy;
    end
    if (free_b) begin
      b_op_r  <= a_op_r;
      b_idx_r <= a_idx_r;
      b_pix_r <= a_pix_r;
      b_r2_r  <= {1'b0, sq_x[20:0]} + {1'b0, sq_y[20:0]};
      b_pcx_r <= cx_r * a_dx_r;
      b_psy_r <= sy_r * a_dy_r;
      b_psx_r <= sx_r * a_dx_r;
      b_pcy_r <= cy_r * a_dy_r;
    end
    if (free_c) begin
      c_op_r     <= b_op_r;
      c_idx_r    <= b_idx_r;
      c_pix_r    <= b_pix_r;
      c_region_r <= c_region_nxt;
      c_x_r      <= ZEN_X - POS_W'(b_pcx_r) - POS_W'(b_psy_r);
      c_y_r      <= ZEN_Y + POS_W'(b_psx_r) - POS_W'(b_pcy_r);
    end
    if (free_o) begin
      o_region_r <= (c_region_r == REGION_SAMPLED && out_of_frame) ?
                    REGION_OUT_FRAME : c_region_r;
    end
  end

  // The half-scale sample window must lie inside the source frame.
  assign hx_pos = $signed({{(POS_W-16-HALF_BITS){1'b0}}, scale_x_r, {HALF_BITS{1'b0}}});
  assign hy_pos = $signed({{(POS_W-16-HALF_BITS){1'b0}}, scale_y_r, {HALF_BITS{1'b0}}});
  assign x_lo   = c_x_r - hx_pos;
  assign x_hi   = c_x_r + hx_pos;
  assign y_lo   = c_y_r - hy_pos;
  assign y_hi   = c_y_r + hy_pos;
  assign out_of_frame = x_lo[POS_W-1] || (x_hi > LIM_X) ||
                        y_lo[POS_W-1] || (y_hi > LIM_Y);

  assign smp_col = c_x_r[FRAC_BITS +: COL_W];
  assign smp_row = c_y_r[FRAC_BITS +: ROW_W];
  assign rd_addr = STORE_AW'(smp_col) +
                   STORE_AW'(STORE_AW'(smp_row) * STORE_AW'(SRC_WIDTH));

  // Loads and requests touch the store in the same stage, so they stay in order.
  assign ram_we = c_v_r && (c_op_r == OP_LOAD);
  assign ram_re = free_o;

  sirr_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (c_idx_r),
    .wdata (c_pix_r),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign out_valid = o_v_r;

  always_comb begin
    out_beat.region = o_region_r;
    unique case (o_region_r)
      REGION_SAMPLED:   out_beat.result_word = ram_rdata;
      REGION_HOLE:      out_beat.result_word = hole_value_r;
      REGION_BEYOND:    out_beat.result_word = '0;
      REGION_OUT_FRAME: out_beat.result_word = '0;
    endcase
  end

  `ASSERT_NEXT(a_rdata_hold, o_v_r && !out_ready, $stable(ram_rdata))
  `ASSERT_NEXT(a_load_no_result, c_v_r && (c_op_r == OP_LOAD) && free_o, !o_v_r)
  `ASSERT_NEXT(a_issue_hold, c_v_r && (c_op_r == OP_REQUEST) && o_v_r && !out_ready, c_v_r && $stable(c_x_r) && $stable(c_y_r))
  `ASSERT_SAME(a_write_in_order, ram_we, free_c)

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sky_image_rotate_remap. Loads source pixels and
// requests output pixels under several register settings, keeps its own copy
// of the frame and of the remap geometry, and checks every result in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sirr_pkg::*;

  localparam int          SRC_W           = 512;
  localparam int          SRC_H           = 256;
  localparam longint      ZEN_COL         = 166;
  localparam longint      ZEN_ROW         = 124;
  localparam longint      ELLIPSE_0916    = 60031;
  localparam int          POS_FRAC        = 26;
  localparam int          WIN_SHIFT       = 13;
  localparam longint      ONE_PX          = longint'(1) <<< POS_FRAC;
  localparam longint      LIM_X           = (SRC_W - 1) * ONE_PX;
  localparam longint      LIM_Y           = (SRC_H - 1) * ONE_PX;
  localparam int          DEPTH           = 131072;
  localparam int unsigned ADDR_MASK       = 131071;
  localparam int          PIPE_LAT        = 3;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          RANDOM_PHASES   = 8;
  localparam int          ITEMS_PER_PHASE = 170;

  // One full register setting, fields in register index order.
  typedef struct {
    logic [9:0]         cx;
    logic [9:0]         cy;
    logic [21:0]        outer;
    logic [21:0]        hole;
    logic signed [15:0] cosv;
    logic signed [15:0] sinv;
    logic [15:0]        sx;
    logic [31:0]        hval;
  } geom_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_beat_t              in_beat   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_beat;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  geom_t       geom;
  logic [31:0] frame_copy [DEPTH];
  bit          frame_written [DEPTH];
  out_beat_t   pending_pixels [$];
  out_beat_t   want;

  int          errors          = 0;
  int          results_seen    = 0;
  int          loads_sent      = 0;
  int          requests_sent   = 0;
  int          settings_used   = 0;
  int          region_hits [4] = '{0, 0, 0, 0};
  int          burst_left      = 0;
  bit          steady          = 1'b0;
  int          spread          = 16;
  int          idle_cycles     = 0;
  logic [31:0] stall_pat       = '1;
  int          stall_left      = 0;
  logic [4:0]  stall_bit       = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sky_image_rotate_remap #(
    .SRC_WIDTH  (SRC_W),
    .SRC_HEIGHT (SRC_H)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endfunction

  // Expected output pixel for the current geometry; addr is the source
  // entry that a sampled pixel reads.
  function automatic out_beat_t remap_pixel(input logic [9:0] col, input logic [9:0] row,
                                            output int unsigned addr);
    out_beat_t r;
    longint    dx, dy, r2, sy, tx, ty, px, py, hx, hy;
    r.result_word = '0;
    r.region      = REGION_SAMPLED;
    addr          = 0;
    dx = longint'(geom.cx) - longint'(col);
    dy = longint'(geom.cy) - longint'(row);
    r2 = dx * dx + dy * dy;
    if (r2 >= longint'(geom.outer)) begin
      r.region = REGION_BEYOND;
    end else if (r2 <= longint'(geom.hole)) begin
      r.region      = REGION_HOLE;
      r.result_word = geom.hval;
    end else begin
      // Vertical scale is 0.916 of the horizontal one, rounded half up in Q4.12.
      sy = longint'((64'(geom.sx) * 64'(ELLIPSE_0916) + 64'd32768) >> 16);
      tx = longint'(geom.cosv) * dx * longint'(geom.sx) + longint'(geom.sinv) * dy * sy;
      ty = longint'(geom.cosv) * dy * sy - longint'(geom.sinv) * dx * longint'(geom.sx);
      px = ZEN_COL * ONE_PX - tx;
      py = ZEN_ROW * ONE_PX - ty;
      hx = longint'(geom.sx) <<< WIN_SHIFT;
      hy = sy <<< WIN_SHIFT;
      if (px - hx < 0 || px + hx > LIM_X || py - hy < 0 || py + hy > LIM_Y) begin
        r.region = REGION_OUT_FRAME;
      end else begin
        addr = 32'((px >>> POS_FRAC) + longint'(SRC_W) * (py >>> POS_FRAC)) & ADDR_MASK;
        r.result_word = frame_written[addr] ? frame_copy[addr] : '0;
      end
    end
    return r;
  endfunction

  // Offers one beat, honoring the burst and gap pattern, and records what
  // the block must do with it once it is accepted.
  task automatic send_beat(input in_beat_t b);
    int          gap;
    int unsigned addr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (b.op == OP_LOAD) begin
      frame_copy[b.load_index]    = b.pixel_word;
      frame_written[b.load_index] = 1'b1;
      loads_sent++;
    end else begin
      pending_pixels.push_back(remap_pixel(b.out_col, b.out_row, addr));
      requests_sent++;
    end
  endtask

  task automatic send_load(input logic [16:0] index, input logic [31:0] word);
    in_beat_t b;
    b.op         = OP_LOAD;
    b.load_index = index;
    b.pixel_word = word;
    b.out_col    = 10'($urandom);
    b.out_row    = 10'($urandom);
    send_beat(b);
  endtask

  // A request that would sample a never-loaded entry gets that entry loaded
  // first, so every read hits defined data.
  task automatic send_request(input logic [9:0] col, input logic [9:0] row);
    out_beat_t   guess;
    int unsigned addr;
    in_beat_t    b;
    guess = remap_pixel(col, row, addr);
    if (guess.region == REGION_SAMPLED && !frame_written[addr]) begin
      send_load(17'(addr), $urandom);
    end
    b.op         = OP_REQUEST;
    b.load_index = 17'($urandom);
    b.pixel_word = $urandom;
    b.out_col    = col;
    b.out_row    = row;
    send_beat(b);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // Loads give no result and may still be in flight.
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_geometry(input geom_t g);
    logic [CFG_DATA_W-1:0] vals [1 << CFG_IDX_W];
    cfg_reg_t              r;
    vals[CFG_CENTER_X]    = CFG_DATA_W'(g.cx);
    vals[CFG_CENTER_Y]    = CFG_DATA_W'(g.cy);
    vals[CFG_OUTER_LIMIT] = CFG_DATA_W'(g.outer);
    vals[CFG_HOLE_LIMIT]  = CFG_DATA_W'(g.hole);
    // Negative rotation terms arrive sign extended; only the low 16 bits count.
    vals[CFG_COS_ROT]     = CFG_DATA_W'(g.cosv);
    vals[CFG_SIN_ROT]     = CFG_DATA_W'(g.sinv);
    vals[CFG_SCALE_X]     = CFG_DATA_W'(g.sx);
    vals[CFG_HOLE_VALUE]  = g.hval;
    r = r.first();
    do begin
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= vals[r];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_valid <= 1'b0;
    geom = g;
    settings_used++;
  endtask

  function automatic geom_t rand_geometry();
    geom_t g;
    int    hr;
    spread = $urandom_range(8, 220);
    hr     = $urandom_range(0, spread / 3);
    g.cx    = 10'($urandom);
    g.cy    = 10'($urandom);
    g.outer = ($urandom_range(0, 7) == 0) ? 22'd2097152 : 22'(spread * spread);
    g.hole  = 22'(hr * hr);
    g.cosv  = 16'($urandom_range(0, 32768) - 16384);
    g.sinv  = 16'($urandom_range(0, 32768) - 16384);
    case ($urandom_range(0, 7))
      0: g.sx = 16'd0;
      1: g.sx = 16'hffff;
      default: g.sx = 16'($urandom_range(1024, 12288));
    endcase
    g.hval = $urandom;
    return g;
  endfunction

  function automatic logic [9:0] near_coord(input logic [9:0] mid);
    int c;
    c = int'(mid) + int'($urandom_range(0, 2 * spread + 8)) - spread - 4;
    if (c < 0) c = 0;
    if (c > 1023) c = 1023;
    return 10'(c);
  endfunction

  task automatic test_reset_defaults();
    // Reset leaves the outer limit at zero, so every request lies beyond it.
    send_request(10'd0, 10'd0);
    send_request(10'd1023, 10'd1023);
    send_request(10'd512, 10'd0);
  endtask

  task automatic test_region_edges();
    settle_idle();
    write_geometry('{10'd512, 10'd512, 22'd2097152, 22'd25,
                     16'sd16384, 16'sd0, 16'd4096, 32'hffff_ffff});
    send_load(17'd0, 32'h0000_0000);
    send_load(17'h1ffff, 32'hffff_ffff);
    send_request(10'd512, 10'd512);
    send_request(10'd517, 10'd512);
    send_request(10'd518, 10'd512);
    // Half a source pixel of window decides the left and right frame edges.
    send_request(10'd346, 10'd512);
    send_request(10'd347, 10'd512);
    send_request(10'd857, 10'd512);
    send_request(10'd0, 10'd0);
    send_request(10'd1023, 10'd1023);
    settle_idle();
    write_geometry('{10'd1023, 10'd1023, 22'd10000, 22'd0,
                     16'sd0, 16'sd16384, 16'd2048, 32'd0});
    send_request(10'd1023, 10'd1023);
    send_request(10'd923, 10'd1023);
    send_request(10'd924, 10'd1023);
    send_request(10'd1023, 10'd924);
  endtask

  task automatic test_scale_extremes();
    settle_idle();
    // With zero scale every sample collapses onto the zenith pixel.
    write_geometry('{10'd0, 10'd0, 22'd2097152, 22'd4,
                     -16'sd16384, 16'sd16384, 16'd0, 32'hffff_ffff});
    send_request(10'd0, 10'd0);
    send_request(10'd2, 10'd0);
    send_request(10'd3, 10'd0);
    send_request(10'd1023, 10'd1023);
    settle_idle();
    write_geometry('{10'd300, 10'd700, 22'd50, 22'd0,
                     -16'sd16384, -16'sd16384, 16'hffff, 32'h1234_5678});
    send_request(10'd300, 10'd700);
    send_request(10'd301, 10'd700);
    send_request(10'd300, 10'd697);
    send_request(10'd297, 10'd703);
  endtask

  task automatic test_random_remap();
    int pick;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle_idle();
      write_geometry(rand_geometry());
      steady = ($urandom_range(0, 3) == 0);
      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 9);
        if (pick < 2) begin
          send_load(17'($urandom), $urandom);
        end else if (pick == 2) begin
          send_request(10'($urandom), 10'($urandom));
        end else begin
          send_request(near_coord(geom.cx), near_coord(geom.cy));
        end
      end
    end
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_pixels.size() == 0) begin
        flag_error($sformatf("unexpected result: word %08h region %0d",
                             out_beat.result_word, out_beat.region));
      end else begin
        want = pending_pixels.pop_front();
        region_hits[int'(want.region)]++;
        if (out_beat.result_word !== want.result_word || out_beat.region !== want.region) begin
          flag_error($sformatf("result %0d: expected %08h region %0d, got %08h region %0d",
                               results_seen, want.result_word, want.region,
                               out_beat.result_word, out_beat.region));
        end
      end
    end
    if (stall_left == 0) begin
      stall_left = 200;
      stall_pat  = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | 32'h1);
    end
    stall_left--;
    stall_bit++;
    out_ready <= stall_pat[stall_bit];
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    geom = '{10'd0, 10'd0, 22'd0, 22'd0, 16'sd16384, 16'sd0, 16'd4096, 32'd0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_region_edges();
    test_scale_extremes();
    test_random_remap();
    settle_idle();
    $display("Sent %0d loads and %0d pixel requests under %0d register settings.",
             loads_sent, requests_sent, settings_used);
    $display("Results: %0d sampled, %0d beyond limit, %0d hole, %0d out of frame.",
             region_hits[int'(REGION_SAMPLED)], region_hits[int'(REGION_BEYOND)],
             region_hits[int'(REGION_HOLE)], region_hits[int'(REGION_OUT_FRAME)]);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

/* sky_image_rotate_remap.f */
+incdir+hw/rtl
hw/rtl/sirr_pkg.sv
hw/rtl/sirr_ram.sv
hw/rtl/sky_image_rotate_remap.sv
tb/tb.sv
